/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks with an asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCBE_ASSERT_SAME(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define PCBE_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("check failed one cycle later");

`endif

/* design/pcbe_pkg.sv */
// ----------------------------------------------------------------------------
// Prefix code byte encoder package
// Operation codes, the result burst type and shared helpers.
// ----------------------------------------------------------------------------
package pcbe_pkg;

	localparam int BYTE_BITS = 8;
	localparam int LEN_W = 6;
	localparam int CNT_W = 3;
	localparam int BURST_MAX = 4;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_ENCODE = 2'd1,
		OP_FINISH = 2'd2
	} pcbe_op_t;

	typedef struct packed {
		logic [BURST_MAX-1:0][BYTE_BITS-1:0] bytes;
		logic [CNT_W-1:0] count;
		logic [31:0] plen;
	} pcbe_burst_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [CNT_W-1:0] b);
		logic [32:0] s;
		s = {1'b0, a} + 33'(b);
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

/* design/pcbe_if.sv */
// ----------------------------------------------------------------------------
// Prefix code byte encoder channels
// Command channel into the encoder and byte stream channel out of it.
// ----------------------------------------------------------------------------
interface pcbe_cmd_if;
	logic valid;
	logic ready;
	logic [1:0] operation;
	logic [7:0] symbol;
	logic [31:0] code_word;
	logic [5:0] code_length;

	modport source(output valid, operation, symbol, code_word, code_length, input ready);
	modport sink(input valid, operation, symbol, code_word, code_length, output ready);
	modport monitor(input valid, ready, operation, symbol, code_word, code_length);
endinterface

interface pcbe_stream_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic last;
	logic [31:0] payload_bytes;

	modport source(output valid, out_byte, last, payload_bytes, input ready);
	modport sink(input valid, out_byte, last, payload_bytes, output ready);
	modport monitor(input valid, ready, out_byte, last, payload_bytes);
endinterface

/* design/pcbe_out_queue.sv */
// ----------------------------------------------------------------------------
// Prefix code byte encoder output queue
// Holds the bytes of one item and sends them one beat per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module pcbe_out_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input pcbe_pkg::pcbe_burst_t push_data,
	output logic can_take,
	pcbe_stream_if.source stream
);
	import pcbe_pkg::*;

	logic [BURST_MAX-1:0][BYTE_BITS-1:0] bytes_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0] plen_q;
	logic pop;

	assign pop = stream.valid & stream.ready;
	assign can_take = (cnt_q == '0) | ((cnt_q == CNT_W'(1)) & stream.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push) begin
			cnt_q <= push_data.count;
		end else if (pop) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			bytes_q <= push_data.bytes;
			plen_q <= push_data.plen;
		end else if (pop) begin
			bytes_q <= bytes_q >> BYTE_BITS;
		end
	end

	assign stream.valid = (cnt_q != '0);
	assign stream.out_byte = bytes_q[0];
	assign stream.last = (cnt_q == CNT_W'(1));
	assign stream.payload_bytes = (cnt_q == CNT_W'(1)) ? plen_q : 32'd0;
endmodule

/* design/prefix_code_byte_encoder.sv */
// ----------------------------------------------------------------------------
// Prefix code byte encoder
// Packs table-driven prefix codes into bytes, most significant bit first.
// ----------------------------------------------------------------------------
//   channel   dir   payload                                   role
//   cmd       in    operation, symbol, code_word, code_length  load, encode, finish
//   stream    out   out_byte, last, payload_bytes              packed bytes
//
// An encode reads the code table in the cycle it is accepted and is packed in
// the stage that holds the registered entry; its bytes then leave one beat per
// cycle while stream is ready. A load writes the table entry when accepted.
// Reset clears the bit accumulator, byte count, stage valid and queue count;
// table entries are undefined until loaded. A stall on stream holds the queue
// and drops cmd.ready once the packing stage is also full.
module prefix_code_byte_encoder #(
	parameter int SYMBOLS = 256,
	parameter int MAX_CODE_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	pcbe_cmd_if.sink cmd,
	pcbe_stream_if.source stream
);
	import pcbe_pkg::*;

	localparam int AW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
	localparam int EW = LEN_W + MAX_CODE_BITS;
	localparam int W = MAX_CODE_BITS + 7;
	localparam int NB = (MAX_CODE_BITS + 7) / 8;
	localparam logic [8:0] SYM_LIMIT = 9'(SYMBOLS);

	logic [EW-1:0] code_mem [SYMBOLS];
	logic [EW-1:0] rd_s1;
	logic valid_s1;
	logic fin_s1;

	logic [6:0] pend_q;
	logic [2:0] pcnt_q;
	logic [31:0] bc_q;

	logic accept;
	logic sym_ok;
	logic wr_en;
	logic rd_en;
	logic enter;
	logic [AW-1:0] addr;
	logic [LEN_W-1:0] len_sat;
	logic [LEN_W-1:0] shamt;
	logic [MAX_CODE_BITS-1:0] code_la;

	logic [LEN_W-1:0] len_s1;
	logic [MAX_CODE_BITS-1:0] code_s1;
	logic [W-1:0] window;
	logic [W-1:0] shifted;
	logic [LEN_W-1:0] total;
	logic [CNT_W-1:0] n_enc;
	logic [6:0] rem;
	logic [BURST_MAX-1:0][BYTE_BITS-1:0] enc_bytes;
	pcbe_burst_t burst;
	logic can_take;
	logic s1_adv;
	logic push;

	assign accept = cmd.valid & cmd.ready;
	assign sym_ok = ({1'b0, cmd.symbol} < SYM_LIMIT);
	assign addr = cmd.symbol[AW-1:0];

	always_comb begin
		wr_en = 1'b0;
		rd_en = 1'b0;
		enter = 1'b0;
		case (cmd.operation)
			OP_LOAD: begin
				wr_en = accept & sym_ok;
			end
			OP_ENCODE: begin
				rd_en = accept & sym_ok;
				enter = accept & sym_ok;
			end
			OP_FINISH: begin
				enter = accept;
			end
			default: begin
				enter = 1'b0;
			end
		endcase
	end

	assign len_sat = (cmd.code_length > LEN_W'(MAX_CODE_BITS)) ?
		LEN_W'(MAX_CODE_BITS) : cmd.code_length;
	assign shamt = LEN_W'(MAX_CODE_BITS) - len_sat;
	assign code_la = cmd.code_word[MAX_CODE_BITS-1:0] << shamt;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			code_mem[addr] <= {len_sat, code_la};
		end
		if (rd_en) begin
			rd_s1 <= code_mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fin_s1 <= 1'b0;
		end else if (enter) begin
			valid_s1 <= 1'b1;
			fin_s1 <= (cmd.operation == OP_FINISH);
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	assign len_s1 = rd_s1[EW-1 -: LEN_W];
	assign code_s1 = rd_s1[MAX_CODE_BITS-1:0];
	assign window = {pend_q, {MAX_CODE_BITS{1'b0}}} | ({code_s1, 7'b0} >> pcnt_q);
	assign total = {3'b0, pcnt_q} + len_s1;
	assign n_enc = total[5:3];
	assign shifted = window << {n_enc, 3'b0};
	assign rem = shifted[W-1 -: 7];

	for (genvar k = 0; k < BURST_MAX; k++) begin : g_bytes
		if (k < NB) begin : g_used
			assign enc_bytes[k] = window[W-1-8*k -: 8];
		end else begin : g_zero
			assign enc_bytes[k] = '0;
		end
	end

	always_comb begin
		burst = '0;
		if (fin_s1) begin
			if (pcnt_q != 3'd0) begin
				burst.bytes[0] = {pend_q, 1'b0};
				burst.bytes[1] = 8'(4'd8 - {1'b0, pcnt_q});
				burst.count = CNT_W'(2);
			end else begin
				burst.bytes[0] = 8'h00;
				burst.count = CNT_W'(1);
			end
			burst.plen = sat_add(bc_q, burst.count);
		end else begin
			burst.bytes = enc_bytes;
			burst.count = n_enc;
		end
	end

	assign s1_adv = valid_s1 & (can_take | (burst.count == '0));
	assign push = s1_adv & (burst.count != '0);
	assign cmd.ready = ~valid_s1 | s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			pcnt_q <= '0;
			bc_q <= '0;
		end else if (s1_adv) begin
			if (fin_s1) begin
				pend_q <= '0;
				pcnt_q <= '0;
				bc_q <= '0;
			end else begin
				pend_q <= rem;
				pcnt_q <= total[2:0];
				bc_q <= sat_add(bc_q, n_enc);
			end
		end
	end

	pcbe_out_queue u_out_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(burst),
		.can_take(can_take),
		.stream(stream)
	);
endmodule

/* design/pcbe_checker.sv */
// ----------------------------------------------------------------------------
// Prefix code byte encoder checker
// Watches the byte stream port and flags malformed results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcbe_checker (
	input logic clk,
	input logic arst_n,
	input logic valid,
	input logic ready,
	input logic [7:0] out_byte,
	input logic last,
	input logic [31:0] payload_bytes
);

	logic [40:0] beat;

	assign beat = {out_byte, last, payload_bytes};

	`PCBE_ASSERT_NEXT(a_stall_hold, clk, arst_n, valid && !ready, valid && $stable(beat))

	`PCBE_ASSERT_SAME(a_len_on_last, clk, arst_n, valid && !last, payload_bytes == 32'd0)

	`PCBE_ASSERT_SAME(a_pad_byte, clk, arst_n, valid && |payload_bytes, last && (out_byte <= 8'd7))

endmodule

bind prefix_code_byte_encoder pcbe_checker u_pcbe_checker (
	.clk(clk),
	.arst_n(arst_n),
	.valid(stream.valid),
	.ready(stream.ready),
	.out_byte(stream.out_byte),
	.last(stream.last),
	.payload_bytes(stream.payload_bytes)
);

/* sim/prefix_code_byte_encoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prefix code byte encoder testbench
// Drives load, encode, finish and unused-opcode beats into the encoder. A
// predictor in this bench follows the code table and the bit packing and
// queues the expected output beats. Each output beat is checked against them
// field by field. Both channels idle at random, and the receiver also holds
// off for a long stretch so that the encoder fills up.
// ----------------------------------------------------------------------------
module prefix_code_byte_encoder_tb;
	import pcbe_pkg::*;

	localparam int HALF_PERIOD = 4;
	localparam int RESET_CYCLES = 7;
	localparam int MAX_BITS = 32;
	localparam int HOLD_CYCLES = 150;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES = 16;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [7:0] out_byte;
		logic last;
		logic [31:0] payload_bytes;
	} stream_beat_t;

	logic clk;
	logic arst_n;

	pcbe_cmd_if cmd_bus();
	pcbe_stream_if byte_bus();

	prefix_code_byte_encoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_bus),
		.stream(byte_bus)
	);

	logic [31:0] tbl_code [256];
	logic [5:0] tbl_len [256];
	bit tbl_loaded [256];
	int known_syms [$];
	logic [6:0] acc_bits;
	logic [2:0] acc_count;
	logic [31:0] msg_bytes;
	stream_beat_t awaited_beats [$];

	int mismatches;
	int items_sent;
	int beats_checked;
	int messages_closed;
	bit calm;
	bit sender_gaps;
	bit hold_request;

	initial begin
		clk = 1'b0;
	end

	always #(HALF_PERIOD) clk = ~clk;

	function automatic logic [31:0] add_sat(input logic [31:0] a, input int b);
		logic [32:0] s;
		s = {1'b0, a} + 33'(b);
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	task automatic predict_beats(input logic [1:0] op, input logic [7:0] sym,
			input logic [31:0] word, input logic [5:0] len);
		logic [63:0] acc;
		logic [5:0] clen;
		logic [2:0] pad;
		int total;
		int nbytes;
		nbytes = 0;
		case (op)
			OP_LOAD: begin
				clen = (len > MAX_BITS) ? 6'(MAX_BITS) : len;
				tbl_code[sym] = 32'(64'(word) & ((64'd1 << clen) - 64'd1));
				tbl_len[sym] = clen;
				if (!tbl_loaded[sym]) begin
					tbl_loaded[sym] = 1'b1;
					known_syms.push_back(sym);
				end
			end
			OP_ENCODE: begin
				clen = tbl_len[sym];
				acc = (64'(acc_bits) << clen) | (64'(tbl_code[sym]) & ((64'd1 << clen) - 64'd1));
				total = acc_count + clen;
				while (total >= 8 && nbytes < 4) begin
					awaited_beats.push_back('{8'(acc >> (total - 8)), 1'b0, 32'd0});
					nbytes++;
					total -= 8;
				end
				if (nbytes > 0) begin
					awaited_beats[awaited_beats.size() - 1].last = 1'b1;
				end
				acc_bits = 7'(acc & ((64'd1 << total) - 64'd1));
				acc_count = 3'(total);
				msg_bytes = add_sat(msg_bytes, nbytes);
			end
			OP_FINISH: begin
				pad = 3'd0;
				if (acc_count != 3'd0) begin
					pad = 3'(8 - acc_count);
					awaited_beats.push_back('{8'({1'b0, acc_bits} << pad), 1'b0, 32'd0});
					nbytes = 1;
				end
				awaited_beats.push_back('{8'(pad), 1'b1,
					add_sat(add_sat(msg_bytes, nbytes), 1)});
				acc_bits = 7'd0;
				acc_count = 3'd0;
				msg_bytes = 32'd0;
				messages_closed++;
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_item(input logic [1:0] op, input logic [7:0] sym,
			input logic [31:0] word, input logic [5:0] len);
		int gap;
		if (sender_gaps && !calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.operation <= op;
		cmd_bus.symbol <= sym;
		cmd_bus.code_word <= word;
		cmd_bus.code_length <= len;
		@(posedge clk);
		while (!cmd_bus.ready) @(posedge clk);
		predict_beats(op, sym, word, len);
		items_sent++;
	endtask

	task automatic send_encode(input logic [7:0] sym);
		send_item(OP_ENCODE, sym, $urandom(), 6'($urandom()));
	endtask

	task automatic send_finish();
		send_item(OP_FINISH, 8'($urandom()), $urandom(), 6'($urandom()));
	endtask

	task automatic load_random_entry();
		int pick;
		logic [5:0] len;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			len = 6'd0;
		end else if (pick == 1) begin
			len = 6'($urandom_range(33, 63));
		end else if (pick < 6) begin
			len = 6'($urandom_range(1, 12));
		end else begin
			len = 6'($urandom_range(13, 32));
		end
		send_item(OP_LOAD, 8'($urandom_range(0, 255)), $urandom(), len);
	endtask

	function automatic logic [7:0] pick_known_symbol();
		return 8'(known_syms[$urandom_range(0, known_syms.size() - 1)]);
	endfunction

	task automatic wait_drained(input int tail);
		cmd_bus.valid <= 1'b0;
		do @(posedge clk); while (awaited_beats.size() != 0);
		repeat (tail) @(posedge clk);
	endtask

	task automatic log_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $realtime);
		end
	endtask

	task automatic test_directed_cases();
		send_item(OP_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd32);
		send_item(OP_LOAD, 8'd255, 32'hDEAD_BEEF, 6'd0);
		send_item(OP_LOAD, 8'd1, 32'h0000_0001, 6'd1);
		send_item(OP_LOAD, 8'd2, 32'hA5A5_A5A5, 6'd63);
		send_item(OP_LOAD, 8'd3, 32'hFFFF_FF00, 6'd8);
		send_item(OP_LOAD, 8'd4, 32'h0000_007F, 6'd7);
		send_item(OP_LOAD, 8'd128, 32'h0000_0002, 6'd2);
		send_finish();
		send_encode(8'd255);
		send_encode(8'd0);
		send_encode(8'd1);
		send_encode(8'd0);
		send_encode(8'd4);
		send_encode(8'd2);
		send_encode(8'd128);
		send_item(OP_UNUSED, 8'($urandom()), $urandom(), 6'($urandom()));
		send_encode(8'd1);
		send_finish();
		send_encode(8'd3);
		send_finish();
		send_encode(8'd1);
		send_encode(8'd128);
		send_finish();
	endtask

	task automatic test_random_messages(input int n_items);
		int sent;
		int msg_len;
		int pick;
		sent = 0;
		while (sent < n_items) begin
			sender_gaps = ($urandom_range(0, 2) != 0);
			msg_len = $urandom_range(1, 12);
			repeat (msg_len) begin
				pick = $urandom_range(0, 19);
				if (pick < 3 || known_syms.size() == 0) begin
					load_random_entry();
					sent++;
				end else if (pick == 3) begin
					send_item(OP_UNUSED, 8'($urandom()), $urandom(), 6'($urandom()));
				end else begin
					send_encode(pick_known_symbol());
					sent++;
				end
			end
			if ($urandom_range(0, 9) != 0) begin
				send_finish();
				sent++;
			end
		end
		sender_gaps = 1'b1;
	endtask

	task automatic test_receiver_hold();
		logic [7:0] long_syms [3];
		long_syms[0] = 8'($urandom_range(0, 255));
		long_syms[1] = 8'($urandom_range(0, 255));
		long_syms[2] = 8'($urandom_range(0, 255));
		send_item(OP_LOAD, long_syms[0], $urandom(), 6'd32);
		send_item(OP_LOAD, long_syms[1], $urandom(), 6'd31);
		send_item(OP_LOAD, long_syms[2], $urandom(), 6'd25);
		sender_gaps = 1'b0;
		hold_request = 1'b1;
		repeat (40) begin
			send_encode(long_syms[$urandom_range(0, 2)]);
		end
		send_finish();
		sender_gaps = 1'b1;
		wait_drained(0);
	endtask

	task automatic test_steady_stream(input int n_items);
		calm = 1'b1;
		repeat (n_items) begin
			if ($urandom_range(0, 7) == 0) begin
				send_finish();
			end else begin
				send_encode(pick_known_symbol());
			end
		end
		send_finish();
	endtask

	always @(posedge clk) begin : check_beats
		stream_beat_t want;
		if (arst_n && byte_bus.valid && byte_bus.ready) begin
			beats_checked++;
			if (awaited_beats.size() == 0) begin
				log_mismatch("unexpected beat, out_byte", 32'd0, 32'(byte_bus.out_byte));
			end else begin
				want = awaited_beats.pop_front();
				if (byte_bus.out_byte !== want.out_byte) begin
					log_mismatch("out_byte", 32'(want.out_byte), 32'(byte_bus.out_byte));
				end
				if (byte_bus.last !== want.last) begin
					log_mismatch("last", 32'(want.last), 32'(byte_bus.last));
				end
				if (byte_bus.payload_bytes !== want.payload_bytes) begin
					log_mismatch("payload_bytes", want.payload_bytes, byte_bus.payload_bytes);
				end
			end
		end
	end

	initial begin : sink_pacing
		int stall;
		int cycle;
		bit quiet;
		quiet = 1'b0;
		cycle = 0;
		byte_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle % 48 == 0) begin
				quiet = ($urandom_range(0, 2) == 0);
			end
			if (hold_request) begin
				hold_request = 1'b0;
				byte_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				byte_bus.ready <= 1'b1;
			end else if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 9);
				byte_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
				byte_bus.ready <= 1'b1;
			end else begin
				byte_bus.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cmd_bus.valid && cmd_bus.ready) || (byte_bus.valid && byte_bus.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("No beat moved for %0d cycles, %0d beats still awaited.",
			WATCHDOG_LIMIT, awaited_beats.size());
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		mismatches = 0;
		items_sent = 0;
		beats_checked = 0;
		messages_closed = 0;
		calm = 1'b0;
		sender_gaps = 1'b1;
		hold_request = 1'b0;
		acc_bits = 7'd0;
		acc_count = 3'd0;
		msg_bytes = 32'd0;
		foreach (tbl_loaded[i]) begin
			tbl_loaded[i] = 1'b0;
			tbl_code[i] = 32'd0;
			tbl_len[i] = 6'd0;
		end
		arst_n <= 1'b0;
		cmd_bus.valid <= 1'b0;
		cmd_bus.operation <= OP_LOAD;
		cmd_bus.symbol <= 8'd0;
		cmd_bus.code_word <= 32'd0;
		cmd_bus.code_length <= 6'd0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_random_messages(340);
		test_receiver_hold();
		test_steady_stream(60);
		wait_drained(TAIL_CYCLES);

		$display("Sent %0d commands and checked %0d output beats over %0d finished messages,",
			items_sent, beats_checked, messages_closed);
		$display("with idle gaps, a long receiver hold-off and a gap-free closing stretch.");
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches in total.", mismatches);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+design
design/pcbe_pkg.sv
design/pcbe_if.sv
design/pcbe_out_queue.sv
design/prefix_code_byte_encoder.sv
design/pcbe_checker.sv
sim/prefix_code_byte_encoder_tb.sv
